// ===== sv/slis_pkg.sv =====
// ---------------------------------------------------------------------------
// slis_pkg
// Shared types and codes for the sorted list insert and search block.
// ---------------------------------------------------------------------------
package slis_pkg;

  localparam int VALUE_W   = 32;
  localparam int POS_OUT_W = 4;
  localparam int CNT_OUT_W = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // per-cell compare results
  typedef struct packed {
    logic lt;        // occupied and stored value smaller than the key
    logic eq;        // occupied and stored value equal to the key
    logic boundary;  // first cell that is not smaller
  } cell_flags_t;

endpackage

// ===== sv/slis_cell.sv =====
// ---------------------------------------------------------------------------
// slis_cell
// One entry of the sorted chain: holds a value, compares it to the key and
// either keeps it, takes the key or takes the left neighbor's value.
// ---------------------------------------------------------------------------
module slis_cell
  import slis_pkg::*;
(
  input  logic                      clk,
  input  logic signed [VALUE_W-1:0] key,
  input  logic                      occupied,
  input  logic                      cmp_en,
  input  logic                      wr_en,
  input  logic signed [VALUE_W-1:0] left_value,
  input  logic                      left_lt,
  output logic signed [VALUE_W-1:0] value,
  output cell_flags_t               flags
);

  logic lt;
  logic eq;

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      lt <= occupied && (value < key);
      eq <= occupied && (value == key);
    end
    if (wr_en) begin
      if (flags.boundary) begin
        value <= key;
      end else if (!lt) begin
        // right of the insert point: shift one place up
        value <= left_value;
      end
    end
  end

  always_comb begin
    flags.lt       = lt;
    flags.eq       = eq;
    flags.boundary = !lt && left_lt;
  end

endmodule

// ===== sv/slis_encoder.sv =====
// ---------------------------------------------------------------------------
// slis_encoder
// Turns the one-hot boundary of the chain into an index and a match flag.
// ---------------------------------------------------------------------------
module slis_encoder
  import slis_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int IDX_W    = 4
)
(
  input  cell_flags_t [CAPACITY-1:0] flags,
  output logic        [IDX_W-1:0]    index,
  output logic                       hit
);

  always_comb begin
    index = '0;
    hit   = 1'b0;
    // boundary is one-hot or empty, so an or of the indexes is exact
    for (int i = 0; i < CAPACITY; i++) begin
      if (flags[i].boundary) begin
        index = index | IDX_W'(i);
      end
      hit = hit | (flags[i].boundary & flags[i].eq);
    end
  end

endmodule

// ===== sv/sorted_list_insert_search_top.sv =====
// ---------------------------------------------------------------------------
// sorted_list_insert_search_top
// Sorted store of signed values with insert and search over a cell chain.
// ---------------------------------------------------------------------------
// Keeps up to CAPACITY signed 32-bit values in ascending order in a row of
// cells, each holding one entry. An insert goes in front of the first stored
// value that is not smaller and returns its position and the new count; an
// insert into a full store is dropped with status set. A search returns
// found and the position of the first equal entry. Each item passes through
// three steps: one to take it, one in which every cell compares its entry to
// the value, and one in which the chain shifts and the result is registered.
// The result stays in an output register, and the block waits in the last
// step only while an earlier result has not been taken. Reset empties the
// store; no clearing pass is needed.
// ---------------------------------------------------------------------------
module sorted_list_insert_search_top
  import slis_pkg::*;
#(
  parameter int CAPACITY = 16
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [0:0]  s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [0] status, [1] found, [5:2] position,
                                 // [10:6] count, [15:11] zero
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  state_t                    state;
  logic                      op;
  logic signed [VALUE_W-1:0] key;
  logic [CNT_W-1:0]          count;

  logic                      res_status;
  logic                      res_found;
  logic [POS_OUT_W-1:0]      res_position;
  logic [CNT_OUT_W-1:0]      res_count;

  logic signed [VALUE_W-1:0] cell_value [CAPACITY];
  cell_flags_t [CAPACITY-1:0] flags;
  logic [CAPACITY-1:0]       occupied;
  logic [IDX_W-1:0]          enc_index;
  logic                      enc_hit;
  logic                      full;
  logic                      proceed;
  logic                      cells_wr;

  assign full     = (count == CNT_W'(CAPACITY));
  assign proceed  = (state == ST_UPD) && (!m_tvalid || m_tready);
  assign cells_wr = proceed && (op == OP_INSERT) && !full;
  assign s_tready = (state == ST_IDLE);

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign occupied[g] = (CNT_W'(g) < count);
      if (g == 0) begin : g_head
        slis_cell u_cell (
          .clk        (clk),
          .key        (key),
          .occupied   (occupied[g]),
          .cmp_en     (state == ST_CMP),
          .wr_en      (cells_wr),
          .left_value (key),
          .left_lt    (1'b1),
          .value      (cell_value[g]),
          .flags      (flags[g])
        );
      end else begin : g_body
        slis_cell u_cell (
          .clk        (clk),
          .key        (key),
          .occupied   (occupied[g]),
          .cmp_en     (state == ST_CMP),
          .wr_en      (cells_wr),
          .left_value (cell_value[g-1]),
          .left_lt    (flags[g-1].lt),
          .value      (cell_value[g]),
          .flags      (flags[g])
        );
      end
    end
  endgenerate

  slis_encoder #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_encoder (
    .flags (flags),
    .index (enc_index),
    .hit   (enc_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // a new result in the same cycle keeps valid high
      if (m_tvalid && m_tready && !proceed) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tuser[0];
            key   <= s_tdata;
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (proceed) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
            if (op == OP_INSERT) begin
              res_found <= 1'b0;
              if (full) begin
                res_status   <= STATUS_FULL;
                res_position <= '0;
                res_count    <= CNT_OUT_W'(count);
              end else begin
                res_status   <= STATUS_OK;
                res_position <= POS_OUT_W'(enc_index);
                res_count    <= CNT_OUT_W'(count + CNT_W'(1));
                count        <= count + CNT_W'(1);
              end
            end else begin
              res_status   <= STATUS_OK;
              res_found    <= enc_hit;
              res_position <= enc_hit ? POS_OUT_W'(enc_index) : '0;
              res_count    <= CNT_OUT_W'(count);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {5'b0, res_count, res_position, res_found, res_status};

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted list insert and search block.
// ---------------------------------------------------------------------------
// A short directed table fills the store through its extremes, duplicates
// and head inserts, then overflows it. A random run of searches and dropped
// inserts follows. Every result is checked field by field against the
// table's expected values or a local sorted-store predictor, with random
// gaps and stalls on both streams and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_top
  import slis_pkg::*;
;

  localparam int STORE_DEPTH  = 16;
  localparam int N_DIRECTED   = 25;
  localparam int N_RANDOM     = 800;
  localparam int N_CALM       = 150;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic                 status;
    logic                 found;
    logic [POS_OUT_W-1:0] position;
    logic [CNT_OUT_W-1:0] count;
  } outcome_t;

  typedef struct packed {
    logic               op;
    logic [VALUE_W-1:0] value;
    logic               fixed_exp;
    outcome_t           want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  // predictor state
  logic signed [VALUE_W-1:0] model_vals [STORE_DEPTH];
  int                        model_count;

  outcome_t expected_q [$];
  int       n_errors;
  bit       idle_on;
  bit       hold_req;
  int       quiet_cycles;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{OP_SEARCH, 32'h0000_0000, 1'b1, '{STATUS_OK,   1'b0, 4'd0,  5'd0}},
    '{OP_INSERT, 32'h0000_0000, 1'b1, '{STATUS_OK,   1'b0, 4'd0,  5'd1}},
    '{OP_INSERT, 32'h7fff_fffe, 1'b1, '{STATUS_OK,   1'b0, 4'd1,  5'd2}},
    // smaller than the head
    '{OP_INSERT, 32'h8000_0000, 1'b1, '{STATUS_OK,   1'b0, 4'd0,  5'd3}},
    '{OP_SEARCH, 32'h8000_0000, 1'b1, '{STATUS_OK,   1'b1, 4'd0,  5'd3}},
    '{OP_SEARCH, 32'h7fff_fffe, 1'b1, '{STATUS_OK,   1'b1, 4'd2,  5'd3}},
    '{OP_SEARCH, 32'h0000_0005, 1'b1, '{STATUS_OK,   1'b0, 4'd0,  5'd3}},
    '{OP_INSERT, 32'h0000_0000, 1'b0, '0},
    '{OP_SEARCH, 32'h0000_0000, 1'b0, '0},
    '{OP_INSERT, 32'hffff_ffff, 1'b1, '{STATUS_OK,   1'b0, 4'd1,  5'd5}},
    '{OP_INSERT, 32'h8000_0000, 1'b0, '0},
    '{OP_INSERT, 32'h7fff_fff0, 1'b0, '0},
    '{OP_INSERT, 32'h0000_0001, 1'b0, '0},
    '{OP_INSERT, 32'hffff_fffe, 1'b0, '0},
    '{OP_INSERT, 32'h4000_0000, 1'b0, '0},
    '{OP_INSERT, 32'hc000_0000, 1'b0, '0},
    '{OP_INSERT, 32'h5555_5555, 1'b0, '0},
    '{OP_INSERT, 32'haaaa_aaaa, 1'b0, '0},
    '{OP_INSERT, 32'h0000_0007, 1'b0, '0},
    '{OP_INSERT, 32'h8000_0001, 1'b0, '0},
    // largest value into the last free slot
    '{OP_INSERT, 32'h7fff_ffff, 1'b1, '{STATUS_OK,   1'b0, 4'd15, 5'd16}},
    // store full, insert dropped
    '{OP_INSERT, 32'h0000_0003, 1'b1, '{STATUS_FULL, 1'b0, 4'd0,  5'd16}},
    '{OP_SEARCH, 32'h0000_0003, 1'b1, '{STATUS_OK,   1'b0, 4'd0,  5'd16}},
    '{OP_SEARCH, 32'h7fff_ffff, 1'b1, '{STATUS_OK,   1'b1, 4'd15, 5'd16}},
    '{OP_SEARCH, 32'h8000_0001, 1'b0, '0}
  };

  sorted_list_insert_search_top #(
    .CAPACITY(STORE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // insert before the first entry that is not smaller, search for first match
  function automatic outcome_t sorted_store_step(logic op, logic signed [VALUE_W-1:0] v);
    outcome_t r;
    int       p;
    int       i;
    r = '0;
    p = 0;
    if (op == OP_INSERT) begin
      if (model_count >= STORE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        while (p < model_count && model_vals[p] < v) p++;
        for (i = model_count; i > p; i--) model_vals[i] = model_vals[i-1];
        model_vals[p] = v;
        model_count++;
        r.position = p[POS_OUT_W-1:0];
      end
    end else begin
      for (i = model_count - 1; i >= 0; i--) begin
        if (model_vals[i] == v) begin
          r.found    = 1'b1;
          r.position = i[POS_OUT_W-1:0];
        end
      end
    end
    r.count = model_count[CNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic send_item(logic op, logic [VALUE_W-1:0] value, logic fixed_exp,
                           outcome_t want);
    outcome_t predicted;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = sorted_store_step(op, value);
    expected_q.push_back(fixed_exp ? want : predicted);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic check_result(logic [15:0] data);
    outcome_t got;
    outcome_t want;
    got.status   = data[0];
    got.found    = data[1];
    got.position = data[5:2];
    got.count    = data[10:6];
    if (expected_q.size() == 0) begin
      $error("result with nothing expected: tdata %h", data);
      n_errors++;
    end else begin
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        n_errors++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        n_errors++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        n_errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        n_errors++;
      end
    end
  endtask

  // output side: check and stall, hold-off counted here
  initial begin
    int stall_left;
    stall_left = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        m_tready   <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic               op;
    logic [VALUE_W-1:0] value;
    int                 pick;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    m_tready     = 1'b0;
    n_errors     = 0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    quiet_cycles = 0;
    model_count  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < N_DIRECTED; k++) begin
      send_item(directed_rows[k].op, directed_rows[k].value,
                directed_rows[k].fixed_exp, directed_rows[k].want);
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 50 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (k >= N_RANDOM - N_CALM) idle_on = 1'b0;
      if (k == N_RANDOM / 3) hold_req = 1'b1;
      op   = ($urandom_range(0, 9) < 3) ? OP_INSERT : OP_SEARCH;
      pick = $urandom_range(0, 9);
      if (model_count > 0 && pick < 4) begin
        value = model_vals[$urandom_range(0, model_count - 1)];
      end else if (model_count > 0 && pick < 6) begin
        value = model_vals[$urandom_range(0, model_count - 1)]
                + ($urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff);
      end else if (pick == 6) begin
        value = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      end else begin
        value = $urandom;
      end
      send_item(op, value, 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
